/* sv/ssc_pkg.sv */
// Shared types, constants and tables for the six-step commutator.
package ssc_pkg;

   localparam int TIME_W = 16;
   localparam int REV_W = 24;
   localparam int REG_W = 16;
   localparam int CSR_IDX_W = 3;
   localparam int DEC_W = 9;
   localparam int GEAR_W = 3;
   localparam int STAGE_W = 3;
   localparam int GEARS_SHIFT = 4;

   typedef enum logic [1:0] {
      KIND_TICK    = 2'd0,
      KIND_PERIOD  = 2'd1,
      KIND_RESTART = 2'd2,
      KIND_NONE    = 2'd3
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_START_STEP = 3'd0,
      CSR_MIN_STEP   = 3'd1,
      CSR_OFFSET     = 3'd2,
      CSR_THR_2      = 3'd3,
      CSR_THR_3      = 3'd4,
      CSR_THR_4      = 3'd5,
      CSR_THR_5      = 3'd6,
      CSR_COARSE     = 3'd7
   } csr_index_type;

   localparam logic [REG_W-1:0] RST_START_STEP = 16'd40000;
   localparam logic [REG_W-1:0] RST_MIN_STEP   = 16'd900;
   localparam logic [REG_W-1:0] RST_OFFSET     = 16'd300;
   localparam logic [REG_W-1:0] RST_THR_2      = 16'd39950;
   localparam logic [REG_W-1:0] RST_THR_3      = 16'd20000;
   localparam logic [REG_W-1:0] RST_THR_4      = 16'd3000;
   localparam logic [REG_W-1:0] RST_THR_5      = 16'd1100;
   localparam logic [REG_W-1:0] RST_COARSE     = 16'd16380;

   localparam logic [DEC_W-1:0]   RST_DECREMENT = 9'd50;
   localparam logic [GEAR_W-1:0]  GEAR_FIRST    = 3'd1;
   localparam logic [GEAR_W-1:0]  GEAR_TOP      = 3'd5;
   localparam logic [STAGE_W-1:0] STAGE_LAST    = 3'd5;

   // Reciprocals: floor(x/1000) for 16-bit x, floor(x/120) for 24-bit x, exact over range
   localparam int                 MS_SHIFT  = 26;
   localparam logic [16:0]        MS_MULT   = 17'd67109;
   localparam logic [9:0]         MS_US     = 10'd1000;
   localparam int                 REV_SHIFT = 31;
   localparam logic [24:0]        REV_MULT  = 25'd17895698;

   typedef logic [GEARS_SHIFT-1:0][REG_W-1:0] thr_type;

   typedef struct packed {
      logic [TIME_W-1:0]      step;
      logic [GEAR_W-1:0]      gear;
      logic [GEARS_SHIFT-1:0] shift_done;
      logic [DEC_W-1:0]       decrement;
   } motion_type;

   typedef struct packed {
      logic [2:0]         phase_pattern;
      logic [STAGE_W-1:0] stage;
      logic [GEAR_W-1:0]  gear;
      logic [TIME_W-1:0]  step_length;
      logic               stage_advanced;
   } rsp_type;

   function automatic logic [2:0] pattern_of_stage(input logic [STAGE_W-1:0] s);
      logic [2:0] p;
      case (s)
         3'd0: p = 3'b001;
         3'd1: p = 3'b101;
         3'd2: p = 3'b100;
         3'd3: p = 3'b110;
         3'd4: p = 3'b010;
         default: p = 3'b011;
      endcase
      return p;
   endfunction

   function automatic logic [DEC_W-1:0] gear_decrement(input logic [1:0] g);
      logic [DEC_W-1:0] d;
      case (g)
         2'd0: d = 9'd300;
         2'd1: d = 9'd50;
         2'd2: d = 9'd2;
         default: d = 9'd1;
      endcase
      return d;
   endfunction

endpackage

/* sv/ssc_stage.sv */
// Stage timer: effective stage length and dwell count update for one tick.
module ssc_stage
   import ssc_pkg::*;
(
   input  logic [TIME_W-1:0] step,
   input  logic [REG_W-1:0]  coarse_thr,
   input  logic [TIME_W-1:0] dwell,
   output logic [TIME_W-1:0] dwell_inc,
   output logic              ended
);

   logic [32:0]       ms_prod;
   logic [6:0]        ms_q;
   logic [16:0]       ms_len;
   logic [TIME_W-1:0] len;

   always_comb begin
      ms_prod = 33'(step) * 33'(MS_MULT);
      ms_q = ms_prod[32:MS_SHIFT];
      ms_len = 17'(ms_q) * 17'(MS_US);
      // round down to whole milliseconds above the coarse threshold
      len = (step > coarse_thr) ? ms_len[TIME_W-1:0] : step;
      dwell_inc = (dwell != {TIME_W{1'b1}}) ? dwell + 1'b1 : dwell;
      ended = (dwell_inc >= len);
   end

endmodule

/* sv/ssc_ramp.sv */
// Acceleration ramp: new step length and gear shifts at the end of a revolution.
module ssc_ramp
   import ssc_pkg::*;
(
   input  motion_type       motion_cur,
   input  logic [REV_W-1:0] rev_period,
   input  logic [REG_W-1:0] min_step,
   input  logic [REG_W-1:0] offset,
   input  thr_type          thr,
   output motion_type       motion_nxt
);

   logic [48:0]       rev_prod;
   logic [17:0]       est;
   logic [17:0]       est_sub;
   logic [TIME_W-1:0] step_top;
   logic [TIME_W-1:0] dec_ext;

   always_comb begin
      rev_prod = 49'(rev_period) * 49'(REV_MULT);
      est = rev_prod[48:REV_SHIFT];
      est_sub = (est > {2'b00, offset}) ? est - {2'b00, offset} : 18'd0;
      step_top = (est_sub > 18'(16'hFFFF)) ? 16'hFFFF : est_sub[TIME_W-1:0];
      dec_ext = {{(TIME_W-DEC_W){1'b0}}, motion_cur.decrement};

      motion_nxt = motion_cur;
      if (motion_cur.step > min_step) begin
         if (motion_cur.gear < GEAR_TOP) begin
            motion_nxt.step = (motion_cur.step > dec_ext) ? motion_cur.step - dec_ext
                                                          : '0;
         end else begin
            motion_nxt.step = step_top;
         end
      end else begin
         motion_nxt.step = min_step;
      end

      // shift up once per threshold crossed, lowest gear first
      for (int g = 0; g < GEARS_SHIFT; g++) begin
         if (motion_nxt.step < thr[g] && !motion_nxt.shift_done[g]) begin
            motion_nxt.shift_done[g] = 1'b1;
            motion_nxt.gear = GEAR_W'(g + 2);
            motion_nxt.decrement = gear_decrement(2'(g));
         end
      end
   end

endmodule

/* sv/ssc_out_buf.sv */
// Two-entry result buffer between the state update and the result channel.
module ssc_out_buf
   import ssc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type push_data,
   output logic    full,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   rsp_type    mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       pop;

   always_comb begin
      pop = rsp_valid && rsp_ready;
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign full = (count_ff == 2'd2);
   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_data = mem_ff[rd_ptr_ff];

endmodule

/* sv/six_step_commutator_with_ramp_core.sv */
// Top level of the open-loop six-step commutator with acceleration ramp.
//
// The request channel takes one beat per event: a microsecond tick, a
// revolution period measurement (req_rev_period_us) or a restart. Every
// accepted beat yields exactly one result beat carrying the phase pattern,
// stage, gear and step length after the event, plus a flag set when a tick
// ended a stage.
// Each beat updates the motion state in the cycle it is accepted; its result
// is registered in a two-entry buffer and presented on the rsp_ channel from
// there, so one beat per cycle is sustained while the receiver keeps up.
// The stage length compare and the top-gear period estimate use constant
// reciprocal multipliers working on the state registers, so both finish
// within the accepting cycle.
// If the receiver stalls, the buffer still takes one more beat; req_ready
// drops only while both entries are occupied.
// Reset (synchronous) loads the register defaults, clears the buffer and
// puts the motor at stage 0, gear 1, step 40000 us.
// The csr_ port writes one register per enabled cycle; write it only while
// the block is idle.
module six_step_commutator_with_ramp_core
   import ssc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_kind,
   input  logic [REV_W-1:0]     req_rev_period_us,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [2:0]           rsp_phase_pattern,
   output logic [STAGE_W-1:0]   rsp_stage,
   output logic [GEAR_W-1:0]    rsp_gear,
   output logic [TIME_W-1:0]    rsp_step_length,
   output logic                 rsp_stage_advanced,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [REG_W-1:0]     csr_data
);

   logic [REG_W-1:0]   start_step_ff, min_step_ff, offset_ff, coarse_ff;
   thr_type            thr_ff;

   logic [TIME_W-1:0]  dwell_ff, dwell_in;
   logic [STAGE_W-1:0] stage_ff, stage_in;
   motion_type         motion_ff, motion_in;
   logic [REV_W-1:0]   rev_ff, rev_in;

   motion_type         motion_ramp;
   logic [TIME_W-1:0]  dwell_inc;
   logic               ended;
   logic               accept;
   logic               advanced;
   logic               buf_full;
   rsp_type            push_data;
   rsp_type            rsp_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_step_ff <= RST_START_STEP;
         min_step_ff <= RST_MIN_STEP;
         offset_ff <= RST_OFFSET;
         thr_ff[0] <= RST_THR_2;
         thr_ff[1] <= RST_THR_3;
         thr_ff[2] <= RST_THR_4;
         thr_ff[3] <= RST_THR_5;
         coarse_ff <= RST_COARSE;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_START_STEP: start_step_ff <= csr_data;
            CSR_MIN_STEP:   min_step_ff <= csr_data;
            CSR_OFFSET:     offset_ff <= csr_data;
            CSR_THR_2:      thr_ff[0] <= csr_data;
            CSR_THR_3:      thr_ff[1] <= csr_data;
            CSR_THR_4:      thr_ff[2] <= csr_data;
            CSR_THR_5:      thr_ff[3] <= csr_data;
            CSR_COARSE:     coarse_ff <= csr_data;
            default: ;
         endcase
      end
   end

   ssc_stage u_stage (
      .step       (motion_ff.step),
      .coarse_thr (coarse_ff),
      .dwell      (dwell_ff),
      .dwell_inc  (dwell_inc),
      .ended      (ended)
   );

   ssc_ramp u_ramp (
      .motion_cur (motion_ff),
      .rev_period (rev_ff),
      .min_step   (min_step_ff),
      .offset     (offset_ff),
      .thr        (thr_ff),
      .motion_nxt (motion_ramp)
   );

   assign req_ready = !buf_full;
   assign accept = req_valid && req_ready;

   always_comb begin
      dwell_in = dwell_ff;
      stage_in = stage_ff;
      motion_in = motion_ff;
      rev_in = rev_ff;
      advanced = 1'b0;
      case (kind_type'(req_kind))
         KIND_TICK: begin
            dwell_in = dwell_inc;
            if (ended) begin
               dwell_in = '0;
               advanced = 1'b1;
               if (stage_ff >= STAGE_LAST) begin
                  stage_in = '0;
                  motion_in = motion_ramp;
               end else begin
                  stage_in = stage_ff + 1'b1;
               end
            end
         end
         KIND_PERIOD: rev_in = req_rev_period_us;
         KIND_RESTART: begin
            dwell_in = '0;
            stage_in = '0;
            motion_in.step = start_step_ff;
            motion_in.gear = GEAR_FIRST;
            motion_in.shift_done = '0;
            motion_in.decrement = RST_DECREMENT;
         end
         default: ;
      endcase

      push_data.phase_pattern = pattern_of_stage(stage_in);
      push_data.stage = stage_in;
      push_data.gear = motion_in.gear;
      push_data.step_length = motion_in.step;
      push_data.stage_advanced = advanced;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dwell_ff <= '0;
         stage_ff <= '0;
         motion_ff.step <= RST_START_STEP;
         motion_ff.gear <= GEAR_FIRST;
         motion_ff.shift_done <= '0;
         motion_ff.decrement <= RST_DECREMENT;
         rev_ff <= '0;
      end else if (accept) begin
         dwell_ff <= dwell_in;
         stage_ff <= stage_in;
         motion_ff <= motion_in;
         rev_ff <= rev_in;
      end
   end

   ssc_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (push_data),
      .full      (buf_full),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_phase_pattern = rsp_data.phase_pattern;
   assign rsp_stage = rsp_data.stage;
   assign rsp_gear = rsp_data.gear;
   assign rsp_step_length = rsp_data.step_length;
   assign rsp_stage_advanced = rsp_data.stage_advanced;

endmodule

/* tb/sv/tb_six_step_commutator_with_ramp_core.sv */
// Self-checking testbench for the six-step commutator: directed table, then random phases.
module tb_six_step_commutator_with_ramp_core;
   import ssc_pkg::*;

   localparam int PHASES          = 8;
   localparam int ITEMS_PER_PHASE = 106;
   localparam int STALL_LIMIT     = 4000;
   localparam int US_PER_MS       = 1000;
   localparam int REV_DIV         = 120;
   localparam int CUT_OF_GEAR [GEARS_SHIFT] = '{300, 50, 2, 1};
   localparam logic [2:0] DRIVE_OF_STAGE [8] =
      '{3'b001, 3'b101, 3'b100, 3'b110, 3'b010, 3'b011, 3'b011, 3'b011};

   // State seen right after reset or a restart with the default start step
   localparam rsp_type IDLE_VIEW = '{3'b001, 3'd0, GEAR_FIRST, RST_START_STEP, 1'b0};

   typedef struct packed {
      kind_type          kind;
      logic [REV_W-1:0]  period;
      logic [4:0]        count;
      logic              typed;
      rsp_type           want;
   } probe_row_type;

   // Rows from FAST_ROW on run with PROBE_SETTING: every tick ends a stage, a ramp every
   // sixth tick, three gears in one pass on the second ramp, saturation on the third.
   localparam int FAST_ROW = 4;
   localparam int PROBE_N  = 8;
   localparam probe_row_type PROBE_ROWS [PROBE_N] = '{
      '{KIND_NONE,    24'd0,        5'd1,  1'b1, IDLE_VIEW},
      '{KIND_PERIOD,  24'd0,        5'd1,  1'b1, IDLE_VIEW},
      '{KIND_RESTART, 24'd0,        5'd1,  1'b1, IDLE_VIEW},
      '{KIND_TICK,    24'd0,        5'd2,  1'b1, IDLE_VIEW},
      '{KIND_RESTART, 24'd0,        5'd1,  1'b0, '0},
      '{KIND_PERIOD,  24'hFFFFFF,   5'd1,  1'b0, '0},
      '{KIND_TICK,    24'hFFFFFF,   5'd18, 1'b0, '0},
      '{KIND_RESTART, 24'd0,        5'd1,  1'b0, '0}
   };
   localparam logic [REG_W-1:0] PROBE_SETTING [8] =
      '{16'd999, 16'd0, 16'd0, 16'd950, 16'd900, 16'd800, 16'd700, 16'd0};

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [1:0]           req_kind = KIND_TICK;
   logic [REV_W-1:0]     req_rev_period_us = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [2:0]           rsp_phase_pattern;
   logic [STAGE_W-1:0]   rsp_stage;
   logic [GEAR_W-1:0]    rsp_gear;
   logic [TIME_W-1:0]    rsp_step_length;
   logic                 rsp_stage_advanced;
   logic                 csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_START_STEP;
   logic [REG_W-1:0]     csr_data = '0;

   // Beat on the request channel carries a fixed expectation when set
   logic    beat_typed = 1'b0;
   rsp_type beat_want = '0;

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int err_count     = 0;
   int req_beats     = 0;
   int rsp_beats     = 0;
   int settings_used = 0;
   int idle_cycles   = 0;

   // Predicted block state and register copy
   logic [REG_W-1:0]       csr_shadow [8];
   logic [TIME_W-1:0]      exp_dwell;
   logic [STAGE_W-1:0]     exp_stage;
   logic [TIME_W-1:0]      exp_step;
   logic [GEAR_W-1:0]      exp_gear;
   logic [GEARS_SHIFT-1:0] exp_shifted;
   logic [DEC_W-1:0]       exp_cut;
   logic [REV_W-1:0]       exp_period;

   rsp_type drive_due [$];

   six_step_commutator_with_ramp_core u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_kind           (req_kind),
      .req_rev_period_us  (req_rev_period_us),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_phase_pattern  (rsp_phase_pattern),
      .rsp_stage          (rsp_stage),
      .rsp_gear           (rsp_gear),
      .rsp_step_length    (rsp_step_length),
      .rsp_stage_advanced (rsp_stage_advanced),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic void restart_motion();
      exp_dwell   = '0;
      exp_stage   = '0;
      exp_step    = csr_shadow[CSR_START_STEP];
      exp_gear    = GEAR_FIRST;
      exp_shifted = '0;
      exp_cut     = RST_DECREMENT;
   endfunction

   function automatic rsp_type predict_drive(input logic [1:0] k, input logic [REV_W-1:0] p);
      rsp_type          r;
      int unsigned      span;
      logic [REV_W-1:0] est;
      logic             advanced;
      advanced = 1'b0;
      if (k == KIND_TICK) begin
         span = exp_step;
         if (exp_step > csr_shadow[CSR_COARSE])
            span = (exp_step / US_PER_MS) * US_PER_MS;
         if (exp_dwell != '1)
            exp_dwell = exp_dwell + 1'b1;
         if (exp_dwell >= span) begin
            exp_dwell = '0;
            advanced  = 1'b1;
            if (exp_stage >= STAGE_LAST) begin
               exp_stage = '0;
               if (exp_step > csr_shadow[CSR_MIN_STEP]) begin
                  if (exp_gear < GEAR_TOP) begin
                     exp_step = (exp_step > exp_cut) ? exp_step - exp_cut : '0;
                  end else begin
                     est = REV_W'(exp_period / REV_DIV);
                     est = (est > csr_shadow[CSR_OFFSET]) ? est - csr_shadow[CSR_OFFSET] : '0;
                     exp_step = (est > {TIME_W{1'b1}}) ? '1 : est[TIME_W-1:0];
                  end
               end else begin
                  exp_step = csr_shadow[CSR_MIN_STEP];
               end
               // several gears may shift in one pass
               for (int g = 0; g < GEARS_SHIFT; g++) begin
                  if (exp_step < csr_shadow[CSR_THR_2 + g] && !exp_shifted[g]) begin
                     exp_shifted[g] = 1'b1;
                     exp_gear       = GEAR_W'(g + 2);
                     exp_cut        = DEC_W'(CUT_OF_GEAR[g]);
                  end
               end
            end else begin
               exp_stage = exp_stage + 1'b1;
            end
         end
      end else if (k == KIND_PERIOD) begin
         exp_period = p;
      end else if (k == KIND_RESTART) begin
         restart_motion();
      end
      r.phase_pattern  = DRIVE_OF_STAGE[exp_stage];
      r.stage          = exp_stage;
      r.gear           = exp_gear;
      r.step_length    = exp_step;
      r.stage_advanced = advanced;
      return r;
   endfunction

   task automatic flag_error(input string msg);
      $display("ERROR: %s", msg);
      err_count++;
   endtask

   task automatic check_field(input string name, input int unsigned got,
                              input int unsigned want);
      if (got != want)
         flag_error($sformatf("result beat %0d: %s is %0d, expected %0d",
                              rsp_beats, name, got, want));
   endtask

   task automatic send_beat(input kind_type k, input logic [REV_W-1:0] p,
                            input logic typed, input rsp_type want);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_kind          <= k;
      req_rev_period_us <= p;
      beat_typed        <= typed;
      beat_want         <= want;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Drop valid and hold until every result is back
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (drive_due.size() != 0) @(posedge clock);
      repeat (2) @(negedge clock);
   endtask

   task automatic apply_setting(input logic [REG_W-1:0] vals [8]);
      for (int i = 0; i < 8; i++) begin
         @(negedge clock);
         csr_wr_en  <= 1'b1;
         csr_index  <= CSR_IDX_W'(i);
         csr_data   <= vals[i];
         csr_shadow[i] = vals[i];
      end
      @(negedge clock);
      csr_wr_en <= 1'b0;
      settings_used++;
   endtask

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin : scoreboard
      rsp_type want;
      logic    moved;
      if (!reset) begin
         moved = 1'b0;
         if (req_valid && req_ready) begin
            want = predict_drive(req_kind, req_rev_period_us);
            if (beat_typed)
               want = beat_want;
            drive_due.push_back(want);
            req_beats++;
            moved = 1'b1;
         end
         if (rsp_valid && rsp_ready) begin
            moved = 1'b1;
            if (drive_due.size() == 0) begin
               flag_error($sformatf("result beat %0d arrived with nothing expected",
                                    rsp_beats));
            end else begin
               want = drive_due.pop_front();
               check_field("phase_pattern", rsp_phase_pattern, want.phase_pattern);
               check_field("stage", rsp_stage, want.stage);
               check_field("gear", rsp_gear, want.gear);
               check_field("step_length", rsp_step_length, want.step_length);
               check_field("stage_advanced", rsp_stage_advanced, want.stage_advanced);
            end
            rsp_beats++;
         end
         if (moved) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
               $display("DONE: errors detected");
               $finish;
            end
         end
      end
   end

   initial begin : stimulus
      logic [REG_W-1:0] vals [8];
      logic [REV_W-1:0] period;
      kind_type         k;
      int               pick;
      csr_shadow[CSR_START_STEP] = RST_START_STEP;
      csr_shadow[CSR_MIN_STEP]   = RST_MIN_STEP;
      csr_shadow[CSR_OFFSET]     = RST_OFFSET;
      csr_shadow[CSR_THR_2]      = RST_THR_2;
      csr_shadow[CSR_THR_3]      = RST_THR_3;
      csr_shadow[CSR_THR_4]      = RST_THR_4;
      csr_shadow[CSR_THR_5]      = RST_THR_5;
      csr_shadow[CSR_COARSE]     = RST_COARSE;
      exp_period = '0;
      restart_motion();

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < PROBE_N; i++) begin
         if (i == FAST_ROW) begin
            drain();
            apply_setting(PROBE_SETTING);
         end
         repeat (PROBE_ROWS[i].count)
            send_beat(PROBE_ROWS[i].kind, PROBE_ROWS[i].period,
                      PROBE_ROWS[i].typed, PROBE_ROWS[i].want);
      end

      for (int ph = 0; ph < PHASES; ph++) begin
         drain();
         if (ph == 1) begin
            foreach (vals[i]) vals[i] = '0;
         end else if (ph == 2) begin
            foreach (vals[i]) vals[i] = '1;
            vals[CSR_START_STEP] = '0;
         end else begin
            // keep stages short so the ramp runs often
            if ($urandom_range(0, 1) == 1) begin
               vals[CSR_START_STEP] = REG_W'($urandom_range(0, 999));
               vals[CSR_COARSE]     = REG_W'($urandom_range(0, vals[CSR_START_STEP]));
            end else begin
               vals[CSR_START_STEP] = REG_W'($urandom_range(0, 12));
               vals[CSR_COARSE]     = REG_W'($urandom_range(vals[CSR_START_STEP], 16'hFFFF));
            end
            if ($urandom_range(0, 3) == 0)
               vals[CSR_MIN_STEP] = REG_W'($urandom_range(0, vals[CSR_START_STEP] + 20));
            else
               vals[CSR_MIN_STEP] = REG_W'($urandom_range(0, vals[CSR_START_STEP] / 2));
            vals[CSR_OFFSET] = REG_W'($urandom_range(0, 400));
            vals[CSR_THR_2]  = REG_W'($urandom_range(0, vals[CSR_START_STEP] + 5));
            vals[CSR_THR_3]  = REG_W'($urandom_range(0, vals[CSR_THR_2]));
            vals[CSR_THR_4]  = REG_W'($urandom_range(0, vals[CSR_THR_3]));
            vals[CSR_THR_5]  = REG_W'($urandom_range(0, vals[CSR_THR_4]));
         end
         apply_setting(vals);

         case (ph % 4)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 46; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 46; end
            default: begin send_idle_pct = 8; rsp_stall_pct = 8; end
         endcase

         send_beat(KIND_RESTART, REV_W'($urandom), 1'b0, '0);
         for (int n = 1; n < ITEMS_PER_PHASE; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 84)      k = KIND_TICK;
            else if (pick < 92) k = KIND_PERIOD;
            else if (pick < 97) k = KIND_RESTART;
            else                k = KIND_NONE;
            if ($urandom_range(0, 2) == 0)
               period = REV_W'($urandom);
            else
               period = REV_W'($urandom_range(0, REV_DIV * (csr_shadow[CSR_OFFSET]
                                              + csr_shadow[CSR_START_STEP] + 50)));
            send_beat(k, period, 1'b0, '0);
         end
      end

      drain();
      repeat (4) @(posedge clock);
      if (drive_due.size() != 0)
         flag_error($sformatf("%0d expected results never arrived", drive_due.size()));
      $display("Ran %0d request beats and %0d result beats over %0d register settings,",
               req_beats, rsp_beats, settings_used);
      $display("covering every event kind, gear shifts, top-gear saturation and idle mixes.");
      if (err_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
